/* design/vmss_pkg.sv */
// Shared types, register map and reset constants for the voice module serial sender.
`default_nettype none

package vmss_pkg;

  // Queue and frame defaults.
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int WORD_BITS_DEF   = 16;

  // Fixed field widths.
  localparam int CMD_W  = 16;
  localparam int GAP_W  = 8;
  localparam int PCNT_W = 10;
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;
  localparam int IDX_W  = 3;

  // Input item kinds carried in tuser.
  typedef enum logic [1:0] {
    MODE_TICK = 2'd0,
    MODE_PUSH = 2'd1,
    MODE_CMD  = 2'd2
  } mode_t;

  // Power-up sequence of the module reset line.
  typedef enum logic [1:0] {
    PH_RESET_LOW  = 2'd0,
    PH_RESET_WAIT = 2'd1,
    PH_RUN        = 2'd2
  } phase_t;

  // Register indexes (byte address is four times the index).
  localparam logic [IDX_W-1:0] REG_FIRST_GAP   = 3'd0;
  localparam logic [IDX_W-1:0] REG_STOP_HOLD   = 3'd1;
  localparam logic [IDX_W-1:0] REG_START_GAP   = 3'd2;
  localparam logic [IDX_W-1:0] REG_RESET_LOW   = 3'd3;
  localparam logic [IDX_W-1:0] REG_RESET_WAIT  = 3'd4;

  // Register reset values.
  localparam logic [GAP_W-1:0]  FIRST_GAP_RST  = 8'd5;
  localparam logic [GAP_W-1:0]  STOP_HOLD_RST  = 8'd48;
  localparam logic [GAP_W-1:0]  START_GAP_RST  = 8'd60;
  localparam logic [PCNT_W-1:0] RESET_LOW_RST  = 10'd16;
  localparam logic [PCNT_W-1:0] RESET_WAIT_RST = 10'd600;

endpackage

`default_nettype wire

/* design/voice_module_serial_sender.sv */
// Top level of the tick-driven two-wire sender for a voice playback module.
`default_nettype none

// Channel   Direction  Ports                      Item contents
// in_       slave      tvalid/tready/tdata/tuser  tick, prompt push or command word
// out_      master     tvalid/tready/tdata        line levels and status after the item
// cfg_      APB slave  psel/penable/pwrite/...    five timing registers
//
// Every accepted item is processed in the cycle it is accepted, and its result
// appears in the output register on the next cycle. The single state update
// stage sets the rate: one item per clock while the consumer takes each result.
// The input side stays ready while a result waits, as long as the consumer
// takes that result in the same cycle; the output register is the only stall point.
// Reset is synchronous and active low; there is no clearing pass after reset.

module voice_module_serial_sender #(
  parameter int QUEUE_DEPTH = vmss_pkg::QUEUE_DEPTH_DEF,
  parameter int WORD_BITS   = vmss_pkg::WORD_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // Input channel.
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // [15:0] word, [16] device_busy, [23:17] zero
  input  wire logic [23:0]                 in_tdata,
  // [1:0] mode
  input  wire logic [1:0]                  in_tuser,
  // Result channel.
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // [0] clk_out, [1] data_out, [2] reset_out, [3] playing, [4] push_dropped, [7:5] zero
  output logic [7:0]                       out_tdata,
  // Configuration port.
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [vmss_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [vmss_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [vmss_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                             cfg_pready
);

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int BITS_W = $clog2(WORD_BITS + 1);

  localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(QUEUE_DEPTH);
  localparam logic [BITS_W-1:0] BITS_FULL = BITS_W'(WORD_BITS);

  // ---------------------------------------------------------------------------
  // Handshake and input field extraction.
  // ---------------------------------------------------------------------------
  logic                         in_fire;
  logic                         out_tvalid_r;
  logic [7:0]                   out_tdata_r;
  logic [vmss_pkg::CMD_W-1:0]   in_word;
  logic                         in_busy;
  vmss_pkg::mode_t              in_mode;

  assign in_tready = !out_tvalid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign in_word   = in_tdata[15:0];
  assign in_busy   = in_tdata[16];
  assign in_mode   = vmss_pkg::mode_t'(in_tuser);

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  logic                              cfg_wr;
  logic [vmss_pkg::IDX_W-1:0]        cfg_idx;
  logic [vmss_pkg::GAP_W-1:0]        first_gap_r;
  logic [vmss_pkg::GAP_W-1:0]        stop_hold_r;
  logic [vmss_pkg::GAP_W-1:0]        start_gap_r;
  logic [vmss_pkg::PCNT_W-1:0]       reset_low_r;
  logic [vmss_pkg::PCNT_W-1:0]       reset_wait_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_gap_r  <= vmss_pkg::FIRST_GAP_RST;
      stop_hold_r  <= vmss_pkg::STOP_HOLD_RST;
      start_gap_r  <= vmss_pkg::START_GAP_RST;
      reset_low_r  <= vmss_pkg::RESET_LOW_RST;
      reset_wait_r <= vmss_pkg::RESET_WAIT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        vmss_pkg::REG_FIRST_GAP:  first_gap_r  <= cfg_pwdata[7:0];
        vmss_pkg::REG_STOP_HOLD:  stop_hold_r  <= cfg_pwdata[7:0];
        vmss_pkg::REG_START_GAP:  start_gap_r  <= cfg_pwdata[7:0];
        vmss_pkg::REG_RESET_LOW:  reset_low_r  <= cfg_pwdata[9:0];
        vmss_pkg::REG_RESET_WAIT: reset_wait_r <= cfg_pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      vmss_pkg::REG_FIRST_GAP:  cfg_prdata = {24'd0, first_gap_r};
      vmss_pkg::REG_STOP_HOLD:  cfg_prdata = {24'd0, stop_hold_r};
      vmss_pkg::REG_START_GAP:  cfg_prdata = {24'd0, start_gap_r};
      vmss_pkg::REG_RESET_LOW:  cfg_prdata = {22'd0, reset_low_r};
      vmss_pkg::REG_RESET_WAIT: cfg_prdata = {22'd0, reset_wait_r};
      default:                  cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sender state.
  // ---------------------------------------------------------------------------
  vmss_pkg::phase_t              phase_r, phase_nxt;
  logic [vmss_pkg::PCNT_W-1:0]   pcnt_r, pcnt_nxt;
  logic                          armed_r, armed_nxt;
  logic [vmss_pkg::GAP_W-1:0]    gap_r, gap_nxt;
  logic [BITS_W-1:0]             bits_r, bits_nxt;
  logic                          sending_r, sending_nxt;
  logic                          clk_level_r, clk_level_nxt;
  logic                          data_level_r, data_level_nxt;
  logic [WORD_BITS-1:0]          shift_r, shift_nxt;
  logic [vmss_pkg::CMD_W-1:0]    pend_r, pend_nxt;
  logic [PTR_W-1:0]              rp_r, rp_nxt;
  logic [PTR_W-1:0]              wp_r, wp_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic                          q_we;
  logic                          q_pop;
  logic                          dropped;
  logic [31:0]                   pend_ext;
  logic [31:0]                   head_ext;

  // Prompt queue: one write port at the tail, one registered read port that
  // always presents the entry at the head. A push into the head slot is
  // forwarded so the head is correct on the very next tick.
  logic [vmss_pkg::CMD_W-1:0]    q_mem [QUEUE_DEPTH];
  logic [vmss_pkg::CMD_W-1:0]    q_head_r;

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[wp_r] <= in_word;
    end
    if (q_we && (wp_r == rp_nxt)) begin
      q_head_r <= in_word;
    end else begin
      q_head_r <= q_mem[rp_nxt];
    end
  end

  assign pend_ext = {16'd0, pend_r};
  assign head_ext = {16'd0, q_head_r};

  // Whole per-item update. The tick path walks the power-up sequence and then
  // one step of the frame: start gap, one half of a data bit, the stop bit or the frame end.
  always_comb begin
    logic go;
    logic fin;

    phase_nxt      = phase_r;
    pcnt_nxt       = pcnt_r;
    armed_nxt      = armed_r;
    gap_nxt        = gap_r;
    bits_nxt       = bits_r;
    sending_nxt    = sending_r;
    clk_level_nxt  = clk_level_r;
    data_level_nxt = data_level_r;
    shift_nxt      = shift_r;
    pend_nxt       = pend_r;
    rp_nxt         = rp_r;
    wp_nxt         = wp_r;
    cnt_nxt        = cnt_r;
    q_we           = 1'b0;
    q_pop          = 1'b0;
    dropped        = 1'b0;
    go             = 1'b0;
    fin            = 1'b0;

    if (in_fire) begin
      unique case (in_mode)
        vmss_pkg::MODE_TICK: begin
          if (armed_r) begin
            go = 1'b1;
            // A reset phase of zero ticks falls through in the same tick.
            if (phase_nxt == vmss_pkg::PH_RESET_LOW) begin
              if (pcnt_nxt < reset_low_r) begin
                pcnt_nxt = pcnt_nxt + 10'd1;
                go       = 1'b0;
              end else begin
                phase_nxt = vmss_pkg::PH_RESET_WAIT;
                pcnt_nxt  = '0;
              end
            end
            if (go && (phase_nxt == vmss_pkg::PH_RESET_WAIT)) begin
              if (pcnt_nxt < reset_wait_r) begin
                pcnt_nxt = pcnt_nxt + 10'd1;
                go       = 1'b0;
              end else begin
                phase_nxt = vmss_pkg::PH_RUN;
                pcnt_nxt  = '0;
              end
            end

            if (go) begin
              // Load a new word between frames; the command skips the busy check.
              if ((bits_r == '0) && !sending_r) begin
                if (pend_r != '0) begin
                  shift_nxt   = pend_ext[WORD_BITS-1:0];
                  pend_nxt    = '0;
                  sending_nxt = 1'b1;
                end else if (!in_busy) begin
                  if (cnt_r == '0) begin
                    armed_nxt = 1'b0;
                    fin       = 1'b1;
                  end else begin
                    shift_nxt   = head_ext[WORD_BITS-1:0];
                    q_pop       = 1'b1;
                    rp_nxt      = (rp_r == PTR_LAST) ? '0 : rp_r + 1'b1;
                    cnt_nxt     = cnt_r - 1'b1;
                    sending_nxt = 1'b1;
                  end
                end
              end

              if (!fin && sending_nxt && (gap_nxt != '0)) begin
                if (bits_nxt == '0) begin
                  // Start gap: the clock goes low in its last ticks.
                  if (gap_nxt < first_gap_r) begin
                    clk_level_nxt = 1'b0;
                  end
                  gap_nxt = gap_nxt - 8'd1;
                  fin     = 1'b1;
                end else if (bits_nxt == BITS_FULL) begin
                  // Stop bit: data low, clock high.
                  data_level_nxt = 1'b0;
                  clk_level_nxt  = 1'b1;
                  gap_nxt        = gap_nxt - 8'd1;
                  fin            = 1'b1;
                end
              end

              if (!fin && (bits_nxt == BITS_FULL) && (gap_nxt == '0)) begin
                bits_nxt    = '0;
                sending_nxt = 1'b0;
                gap_nxt     = start_gap_r;
                fin         = 1'b1;
              end

              if (!fin && (bits_nxt < BITS_FULL) && sending_nxt) begin
                if (!clk_level_nxt) begin
                  gap_nxt        = stop_hold_r;
                  data_level_nxt = data_level_nxt | shift_nxt[WORD_BITS-1];
                  shift_nxt      = {shift_nxt[WORD_BITS-2:0], 1'b0};
                  bits_nxt       = bits_nxt + 1'b1;
                  clk_level_nxt  = 1'b1;
                end else begin
                  clk_level_nxt  = 1'b0;
                  data_level_nxt = 1'b0;
                end
              end
            end
          end
        end
        vmss_pkg::MODE_PUSH: begin
          if (cnt_r == CNT_FULL) begin
            dropped = 1'b1;
          end else begin
            q_we    = 1'b1;
            wp_nxt  = (wp_r == PTR_LAST) ? '0 : wp_r + 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end
          armed_nxt = 1'b1;
        end
        vmss_pkg::MODE_CMD: begin
          pend_nxt = in_word;
        end
        default: ;
      endcase
    end

    // Writing first_gap during power-up also sets the gap before the first word.
    if (cfg_wr && (cfg_idx == vmss_pkg::REG_FIRST_GAP) && (phase_r != vmss_pkg::PH_RUN)) begin
      gap_nxt = cfg_pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= vmss_pkg::PH_RESET_LOW;
      pcnt_r       <= '0;
      armed_r      <= 1'b1;
      gap_r        <= vmss_pkg::FIRST_GAP_RST;
      bits_r       <= '0;
      sending_r    <= 1'b0;
      clk_level_r  <= 1'b0;
      data_level_r <= 1'b0;
      shift_r      <= '0;
      pend_r       <= '0;
      rp_r         <= '0;
      wp_r         <= '0;
      cnt_r        <= '0;
    end else begin
      phase_r      <= phase_nxt;
      pcnt_r       <= pcnt_nxt;
      armed_r      <= armed_nxt;
      gap_r        <= gap_nxt;
      bits_r       <= bits_nxt;
      sending_r    <= sending_nxt;
      clk_level_r  <= clk_level_nxt;
      data_level_r <= data_level_nxt;
      shift_r      <= shift_nxt;
      pend_r       <= pend_nxt;
      rp_r         <= rp_nxt;
      wp_r         <= wp_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register. It holds until taken, and is replaced when a new item is
  // accepted in the same cycle that the old result leaves.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (in_fire) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_tdata_r <= {3'd0, dropped, armed_nxt, (phase_nxt != vmss_pkg::PH_RESET_LOW),
                      data_level_nxt, clk_level_nxt};
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // While the module is held in reset, both serial lines stay low.
  a_lines_low_in_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == vmss_pkg::PH_RESET_LOW) |-> (!clk_level_r && !data_level_r))
    else $error("serial lines active while module reset is low");

  // The queue fill never passes its depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("queue entry count beyond depth");

  // A prompt is only taken from a queue that holds one.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (cnt_r != '0))
    else $error("pop from empty prompt queue");

  // A waiting drop report means the queue is still full.
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tdata_r[4]) |-> (cnt_r == CNT_FULL))
    else $error("dropped push reported with room in queue");

  // The bit counter never runs past one word.
  a_bits_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bits_r <= BITS_FULL)
    else $error("bit counter beyond word length");

endmodule

`default_nettype wire

/* verif/voice_module_serial_sender_tb.sv */
// Self-checking testbench for the voice module serial sender: predicted line levels per item.
`default_nettype none

module voice_module_serial_sender_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The tuser field can carry a fourth kind that the block must ignore.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int WORD_BITS = vmss_pkg::WORD_BITS_DEF;
  localparam int QUEUE_DEPTH = vmss_pkg::QUEUE_DEPTH_DEF;

  // Line levels and status of one result item, clk_out in bit 0 as on out_tdata.
  typedef struct packed {
    logic push_dropped;
    logic playing;
    logic reset_out;
    logic data_out;
    logic clk_out;
  } levels_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // [15:0] word, [16] device_busy, [23:17] zero
  logic [23:0] in_tdata = '0;
  // [1:0] mode
  logic [1:0]  in_tuser = '0;

  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [0] clk_out, [1] data_out, [2] reset_out, [3] playing, [4] push_dropped, [7:5] zero
  logic [7:0]  out_tdata;

  logic                        cfg_psel = 1'b0;
  logic                        cfg_penable = 1'b0;
  logic                        cfg_pwrite = 1'b0;
  logic [vmss_pkg::CFG_AW-1:0] cfg_paddr = '0;
  logic [vmss_pkg::CFG_DW-1:0] cfg_pwdata = '0;
  logic [vmss_pkg::CFG_DW-1:0] cfg_prdata;
  logic                        cfg_pready;

  voice_module_serial_sender DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 8 ns clock.
  initial begin
    forever #4 clk = ~clk;
  end

  // Hard limit on the run. The slowest correct run stays well below a tenth of this.
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor of the sender. It keeps its own copy of the timing registers,
  // the prompt ring, the power-up sequencer and the framing state, and is
  // advanced once for every item that the block accepts.
  // ---------------------------------------------------------------------------
  logic [7:0]  first_gap_r, stop_hold_r, start_gap_r;
  logic [9:0]  reset_low_r, reset_wait_r;

  logic [15:0]       prompt_ring [QUEUE_DEPTH];
  logic [3:0]        ring_rd, ring_wr;
  int                ring_fill;
  logic [15:0]       cmd_waiting;
  logic [15:0]       shift_reg;
  int                bit_index;
  logic              frame_active;
  logic [7:0]        gap_left;
  logic              clk_line, data_line;
  int                power_count;
  vmss_pkg::phase_t  power_phase;
  logic              armed_now;

  // Figures for the closing summary.
  int prompts_framed, commands_framed, pushes_dropped, register_writes;

  function automatic void clear_sender_state();
    first_gap_r  = vmss_pkg::FIRST_GAP_RST;
    stop_hold_r  = vmss_pkg::STOP_HOLD_RST;
    start_gap_r  = vmss_pkg::START_GAP_RST;
    reset_low_r  = vmss_pkg::RESET_LOW_RST;
    reset_wait_r = vmss_pkg::RESET_WAIT_RST;
    ring_rd      = '0;
    ring_wr      = '0;
    ring_fill    = 0;
    cmd_waiting  = '0;
    shift_reg    = '0;
    bit_index    = 0;
    frame_active = 1'b0;
    gap_left     = vmss_pkg::FIRST_GAP_RST;
    clk_line     = 1'b0;
    data_line    = 1'b0;
    power_count  = 0;
    power_phase  = vmss_pkg::PH_RESET_LOW;
    armed_now    = 1'b1;
  endfunction

  // A register write; values are cut to the register width.
  function automatic void apply_register(logic [vmss_pkg::IDX_W-1:0] idx, logic [31:0] value);
    case (idx)
      vmss_pkg::REG_FIRST_GAP: begin
        first_gap_r = value[7:0];
        // While the power-up sequence runs, the first frame picks up the new gap.
        if (power_phase != vmss_pkg::PH_RUN) gap_left = value[7:0];
      end
      vmss_pkg::REG_STOP_HOLD:  stop_hold_r  = value[7:0];
      vmss_pkg::REG_START_GAP:  start_gap_r  = value[7:0];
      vmss_pkg::REG_RESET_LOW:  reset_low_r  = value[9:0];
      vmss_pkg::REG_RESET_WAIT: reset_wait_r = value[9:0];
      default: ;
    endcase
  endfunction

  // One tick of the framing logic once power-up is over.
  function automatic void advance_frame(logic busy);
    if (bit_index == 0 && !frame_active) begin
      if (cmd_waiting != 0) begin
        // A command goes out first and ignores the busy pin.
        shift_reg    = cmd_waiting;
        cmd_waiting  = '0;
        frame_active = 1'b1;
        commands_framed++;
      end else if (!busy) begin
        if (ring_fill == 0) begin
          armed_now = 1'b0;
          return;
        end
        shift_reg    = prompt_ring[ring_rd];
        ring_rd      = ring_rd + 4'd1;
        ring_fill--;
        frame_active = 1'b1;
        prompts_framed++;
      end
    end

    if (frame_active && gap_left != 0) begin
      if (bit_index == 0) begin
        // Start gap: the clock is pulled low for its last ticks only.
        if (gap_left < first_gap_r) clk_line = 1'b0;
        gap_left--;
        return;
      end
      if (bit_index == WORD_BITS) begin
        // Stop bit: data low, clock high.
        data_line = 1'b0;
        clk_line  = 1'b1;
        gap_left--;
        return;
      end
    end

    if (bit_index == WORD_BITS && gap_left == 0) begin
      bit_index    = 0;
      frame_active = 1'b0;
      gap_left     = start_gap_r;
      return;
    end

    if (bit_index < WORD_BITS && frame_active) begin
      if (!clk_line) begin
        // Data is set with the clock low, then the clock rises.
        gap_left  = stop_hold_r;
        data_line = data_line | shift_reg[WORD_BITS-1];
        shift_reg = shift_reg << 1;
        bit_index++;
        clk_line  = 1'b1;
      end else begin
        clk_line  = 1'b0;
        data_line = 1'b0;
      end
    end
  endfunction

  // One time tick: power-up sequence first, then framing.
  function automatic void advance_tick(logic busy);
    if (!armed_now) return;
    if (power_phase == vmss_pkg::PH_RESET_LOW) begin
      if (power_count < reset_low_r) begin
        power_count++;
        return;
      end
      power_phase = vmss_pkg::PH_RESET_WAIT;
      power_count = 0;
    end
    if (power_phase == vmss_pkg::PH_RESET_WAIT) begin
      if (power_count < reset_wait_r) begin
        power_count++;
        return;
      end
      power_phase = vmss_pkg::PH_RUN;
      power_count = 0;
    end
    advance_frame(busy);
  endfunction

  // Levels that the block reports after one accepted item.
  function automatic levels_t line_levels_after(logic [1:0] mode, logic [15:0] word,
                                                logic busy);
    levels_t lv;
    logic dropped;
    dropped = 1'b0;
    if (mode == vmss_pkg::MODE_TICK) begin
      advance_tick(busy);
    end else if (mode == vmss_pkg::MODE_PUSH) begin
      if (ring_fill >= QUEUE_DEPTH) begin
        dropped = 1'b1;
        pushes_dropped++;
      end else begin
        prompt_ring[ring_wr] = word;
        ring_wr = ring_wr + 4'd1;
        ring_fill++;
      end
      armed_now = 1'b1;
    end else if (mode == vmss_pkg::MODE_CMD) begin
      cmd_waiting = word;
    end
    lv.clk_out      = clk_line;
    lv.data_out     = data_line;
    lv.reset_out    = (power_phase != vmss_pkg::PH_RESET_LOW);
    lv.playing      = armed_now;
    lv.push_dropped = dropped;
    return lv;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard. Results come back in the order in which items were accepted,
  // so one queue of predicted levels is enough.
  // ---------------------------------------------------------------------------
  levels_t expected_levels[$];
  int      error_count;
  int      results_seen;
  int      items_accepted;

  task automatic log_failure(input string msg);
    error_count++;
    if (error_count <= 10) $display("mismatch %0d at %0t: %s", error_count, $realtime, msg);
  endtask

  always @(posedge clk) begin
    levels_t got;
    levels_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      got = levels_t'(out_tdata[4:0]);
      if (expected_levels.size() == 0) begin
        log_failure($sformatf("result %0d arrived with no item pending: %b",
                              results_seen, got));
      end else begin
        want = expected_levels.pop_front();
        if (got !== want) begin
          log_failure($sformatf({"result %0d clk/data/rst/play/drop expected ",
                                 "%b/%b/%b/%b/%b got %b/%b/%b/%b/%b"}, results_seen,
                                want.clk_out, want.data_out, want.reset_out, want.playing,
                                want.push_dropped, got.clk_out, got.data_out,
                                got.reset_out, got.playing, got.push_dropped));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink. It alternates ready stretches with stalls of random length.
  // Once, after enough results have gone by, it holds off for a long stretch
  // so that the output register fills and the block has to push back on its
  // input while items keep being offered.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int  ready_len;
    int  stall_len;
    bit  long_hold_done;
    long_hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      ready_len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6) : $urandom_range(30, 80);
      out_tready <= 1'b1;
      repeat (ready_len) @(posedge clk);
      if (!long_hold_done && results_seen >= 100) begin
        long_hold_done = 1'b1;
        stall_len = 90;
      end else begin
        stall_len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3) : $urandom_range(8, 25);
      end
      out_tready <= 1'b0;
      repeat (stall_len) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Item source.
  // ---------------------------------------------------------------------------
  bit sender_gaps_on = 1'b1;

  function automatic int sender_gap();
    int pick;
    if (!sender_gaps_on) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Offers one item and records its prediction once it is taken. Called on a
  // rising edge; returns on the edge at which the item was accepted.
  task automatic send_item(input logic [1:0] mode, input logic [15:0] word, input logic busy);
    int idle;
    idle = sender_gap();
    if (idle > 0) begin
      in_tvalid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, busy, word};
    in_tuser  <= mode;
    do @(posedge clk); while (!in_tready);
    expected_levels.push_back(line_levels_after(mode, word, busy));
    items_accepted++;
  endtask

  // Stops offering and waits until every predicted result has come back, with
  // an extra wait for the output register.
  task automatic drain_results();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    while (expected_levels.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  // APB write of one register, then a read back of the stored value.
  task automatic write_register(input logic [vmss_pkg::IDX_W-1:0] idx,
                                input logic [31:0] value);
    logic [31:0] stored;
    logic [31:0] readback;
    stored = (idx == vmss_pkg::REG_RESET_LOW || idx == vmss_pkg::REG_RESET_WAIT)
             ? (value & 32'h3FF) : (value & 32'hFF);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    apply_register(idx, value);
    register_writes++;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    readback = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (readback !== stored)
      log_failure($sformatf("register %0d read back %h, expected %h", idx, readback, stored));
    // The bus goes idle between transfers.
    @(posedge clk);
  endtask

  task automatic set_timing(input logic [31:0] first_gap, input logic [31:0] stop_hold,
                            input logic [31:0] start_gap, input logic [31:0] reset_low,
                            input logic [31:0] reset_wait);
    write_register(vmss_pkg::REG_FIRST_GAP, first_gap);
    write_register(vmss_pkg::REG_STOP_HOLD, stop_hold);
    write_register(vmss_pkg::REG_START_GAP, start_gap);
    write_register(vmss_pkg::REG_RESET_LOW, reset_low);
    write_register(vmss_pkg::REG_RESET_WAIT, reset_wait);
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Power-up: a push while the reset line is still low, then ticks through a
  // zero-length reset-low phase and into a short wait phase.
  task automatic test_power_up();
    send_item(vmss_pkg::MODE_PUSH, 16'h8000, 1'b0);
    send_item(vmss_pkg::MODE_TICK, 16'hFFFF, 1'b1);
    repeat (3) send_item(vmss_pkg::MODE_TICK, 16'($urandom), 1'($urandom_range(0, 1)));
  endtask

  // Fills the prompt ring with the extreme words and random ones, then pushes
  // twice more into the full ring; both of those must be dropped.
  task automatic test_queue_full();
    send_item(vmss_pkg::MODE_PUSH, 16'h0000, 1'b1);
    send_item(vmss_pkg::MODE_PUSH, 16'hFFFF, 1'b0);
    send_item(vmss_pkg::MODE_PUSH, 16'h0001, 1'b1);
    repeat (12) send_item(vmss_pkg::MODE_PUSH, 16'($urandom), 1'($urandom_range(0, 1)));
    send_item(vmss_pkg::MODE_PUSH, 16'h7FFE, 1'b0);
    send_item(vmss_pkg::MODE_PUSH, 16'hAAAA, 1'b1);
  endtask

  // Commands: one that is cleared again by a zero, one that stays, the unused
  // kind that must change nothing, and a busy tick that still takes the command.
  task automatic test_command();
    send_item(vmss_pkg::MODE_CMD, 16'h5A5A, 1'b0);
    send_item(vmss_pkg::MODE_CMD, 16'h0000, 1'b1);
    send_item(vmss_pkg::MODE_CMD, 16'hC3C3, 1'b0);
    send_item(MODE_UNUSED, 16'hFFFF, 1'b1);
    send_item(vmss_pkg::MODE_TICK, 16'h0000, 1'b1);
  endtask

  // Random traffic. Most of it is well-formed: a few prompts, sometimes a
  // command, then a run of ticks with the busy pin mostly low so that words
  // actually get framed and the ring drains. The rest is single random items
  // of any kind, including the ignored one, which does not count.
  task automatic test_random_traffic(input int item_goal);
    int sent;
    int n;
    logic [1:0] kind;
    sent = 0;
    while (sent < item_goal) begin
      sender_gaps_on = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 9) < 8) begin
        n = $urandom_range(1, 4);
        repeat (n) send_item(vmss_pkg::MODE_PUSH, 16'($urandom), 1'($urandom_range(0, 1)));
        sent += n;
        if ($urandom_range(0, 3) == 0) begin
          send_item(vmss_pkg::MODE_CMD, 16'($urandom_range(1, 16'hFFFF)),
                    1'($urandom_range(0, 1)));
          sent++;
        end
        n = $urandom_range(20, 60);
        repeat (n) send_item(vmss_pkg::MODE_TICK, 16'($urandom), ($urandom_range(0, 7) == 0));
        sent += n;
      end else begin
        kind = 2'($urandom_range(0, 3));
        send_item(kind, 16'($urandom), 1'($urandom_range(0, 1)));
        if (kind != MODE_UNUSED) sent++;
      end
    end
    sender_gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of the run.
  // ---------------------------------------------------------------------------
  initial begin
    clear_sender_state();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Short frames and a short power-up. The upper bits of the first value are
    // junk that the register must discard; the first-gap write also reloads
    // the gap of the first frame since power-up has not finished.
    set_timing(32'hDEAD_1203, 32'd2, 32'd4, 32'h0000_FC00, 32'd4);
    test_power_up();
    test_queue_full();
    test_command();
    test_random_traffic(130);
    drain_results();

    // Upper extremes of every register. Frames are long now, so only part of
    // a word goes out in this phase.
    set_timing(32'd255, 32'd255, 32'd255, 32'd1023, 32'd1023);
    test_random_traffic(60);
    drain_results();

    // Lower extremes: one-tick gaps and stop bits, zero reset-low ticks.
    set_timing(32'hFFFF_FF01, 32'd1, 32'h0000_0101, 32'd0, 32'd0);
    test_random_traffic(150);
    drain_results();

    if (expected_levels.size() != 0)
      log_failure($sformatf("%0d results never arrived", expected_levels.size()));

    $display("Covered %0d items and %0d results over %0d register writes.",
             items_accepted, results_seen, register_writes);
    $display("Framed %0d prompts and %0d commands; %0d pushes hit a full ring.",
             prompts_framed, commands_framed, pushes_dropped);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d failures in total.", error_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
